>>> design/bcpd_pkg.sv
package bcpd_pkg;

    // Field widths of one tick and of one result.
    localparam int COUNT_W = 16;
    localparam int ANGLE_W = 16;
    localparam int RATE_W  = 24;
    localparam int DRIVE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;

    // Internal widths.
    localparam int BIAS_W  = ANGLE_W + 1;      // angle minus setpoint
    localparam int SSUM_W  = COUNT_W + 1;      // left plus right
    localparam int FILT_W  = 26;               // filtered speed, Q18.8
    localparam int INTEG_W = 24;               // speed integral, Q16.8
    localparam int MA_W    = FILT_W + 1;       // multiplier operand a
    localparam int MB_W    = GAIN_W + 1;       // multiplier operand b
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int UPR_W   = 30;               // upright term after truncation
    localparam int SPD_W   = 20;               // speed term after truncation
    localparam int SUM_W   = UPR_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_LIMIT     = 3'd5;

    // Filter weights (old 179/256, new 77/256 scaled by 256 for Q8) and
    // the integral bound of +/-10000.0 in Q16.8.
    localparam logic [GAIN_W-1:0]  FILT_OLD_WT  = 16'd179;
    localparam logic [GAIN_W-1:0]  FILT_NEW_WT  = 16'd19712;
    localparam logic [INTEG_W-1:0] INTEG_LIMIT  = 24'd2560000;

    typedef enum logic [2:0] {
        MUL_BIAS_KP,
        MUL_RATE_KD,
        MUL_FILT_OLD,
        MUL_SSUM_NEW,
        MUL_FILT_KP,
        MUL_INTEG_KI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     upd_upright;
        logic     upd_filt;
        logic     upd_integ;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_status;

endpackage

>>> design/bcpd_ctrl.sv
module bcpd_ctrl
    import bcpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_M0   = 10'b00_0000_0010,
        S_M1   = 10'b00_0000_0100,
        S_M2   = 10'b00_0000_1000,
        S_M3   = 10'b00_0001_0000,
        S_M4   = 10'b00_0010_0000,
        S_M5   = 10'b00_0100_0000,
        S_M6   = 10'b00_1000_0000,
        S_M7   = 10'b01_0000_0000,
        S_M8   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load_in: 1'b0, mul_sel: MUL_BIAS_KP, acc_op: ACC_HOLD,
                    upd_upright: 1'b0, upd_filt: 1'b0, upd_integ: 1'b0,
                    out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_M0;
                end
            end
            S_M0: begin
                o_cmd.mul_sel = MUL_BIAS_KP;
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.mul_sel = MUL_RATE_KD;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul_sel = MUL_FILT_OLD;
                o_cmd.acc_op  = ACC_ADD;
                n_state = S_M3;
            end
            S_M3: begin
                o_cmd.mul_sel     = MUL_SSUM_NEW;
                o_cmd.upd_upright = 1'b1;
                o_cmd.acc_op      = ACC_LOAD;
                n_state = S_M4;
            end
            S_M4: begin
                o_cmd.upd_filt = 1'b1;
                n_state = S_M5;
            end
            S_M5: begin
                o_cmd.upd_integ = 1'b1;
                o_cmd.mul_sel   = MUL_FILT_KP;
                n_state = S_M6;
            end
            S_M6: begin
                o_cmd.mul_sel = MUL_INTEG_KI;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_M7;
            end
            S_M7: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_M8;
            end
            S_M8: begin
                if (!i_status.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/bcpd_datapath.sv
module bcpd_datapath
    import bcpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic [71:0]          i_s_tdata,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DRIVE_W-1:0]   o_m_tdata,
    output logic                 o_m_tuser
);

    // Configuration registers.
    logic [ANGLE_W-1:0] r_bal_angle;
    logic [GAIN_W-1:0]  r_upr_kp;
    logic [GAIN_W-1:0]  r_upr_kd;
    logic [GAIN_W-1:0]  r_spd_kp;
    logic [GAIN_W-1:0]  r_spd_ki;
    logic [LIM_W-1:0]   r_pwm_lim;

    // Captured tick and working values.
    logic [BIAS_W-1:0]  r_bias;
    logic [RATE_W-1:0]  r_rate;
    logic [SSUM_W-1:0]  r_ssum;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [UPR_W-1:0]   r_upright;
    logic [FILT_W-1:0]  r_filt;
    logic [INTEG_W-1:0] r_integ;

    logic [COUNT_W-1:0] w_left;
    logic [COUNT_W-1:0] w_right;
    logic [ANGLE_W-1:0] w_angle;
    logic [MA_W-1:0]    w_mul_a;
    logic [MB_W-1:0]    w_mul_b;
    logic [ACC_W-1:0]   w_prod_ext;
    logic [ACC_W-1:0]   w_acc_sum;
    logic [ACC_W-1:0]   w_upr_adj;
    logic [ACC_W-1:0]   w_spd_adj;
    logic [INTEG_W+2:0] w_integ_sum;
    logic [INTEG_W-1:0] w_integ_next;
    logic [SPD_W-1:0]   w_speed;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_lim_pos;
    logic [SUM_W-1:0]   w_lim_neg;
    logic [DRIVE_W-1:0] w_drive;

    assign w_left  = i_s_tdata[15:0];
    assign w_right = i_s_tdata[31:16];
    assign w_angle = i_s_tdata[47:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal_angle <= 16'hFF00;
            r_upr_kp    <= 16'd3200;
            r_upr_kd    <= 16'd320;
            r_spd_kp    <= 16'd13107;
            r_spd_ki    <= 16'd66;
            r_pwm_lim   <= 15'd7200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BALANCE_ANGLE: r_bal_angle <= i_cfg_data;
                CFG_UPRIGHT_KP:    r_upr_kp    <= i_cfg_data;
                CFG_UPRIGHT_KD:    r_upr_kd    <= i_cfg_data;
                CFG_SPEED_KP:      r_spd_kp    <= i_cfg_data;
                CFG_SPEED_KI:      r_spd_ki    <= i_cfg_data;
                CFG_PWM_LIMIT:     r_pwm_lim   <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bias <= {w_angle[ANGLE_W-1], w_angle}
                      - {r_bal_angle[ANGLE_W-1], r_bal_angle};
            r_ssum <= {w_left[COUNT_W-1], w_left} + {w_right[COUNT_W-1], w_right};
            r_rate <= i_s_tdata[71:48];
        end
    end

    // Shared multiplier: signed operand a against a zero-extended gain.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_BIAS_KP: begin
                w_mul_a = {{(MA_W-BIAS_W){r_bias[BIAS_W-1]}}, r_bias};
                w_mul_b = {1'b0, r_upr_kp};
            end
            MUL_RATE_KD: begin
                w_mul_a = {{(MA_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
                w_mul_b = {1'b0, r_upr_kd};
            end
            MUL_FILT_OLD: begin
                w_mul_a = {r_filt[FILT_W-1], r_filt};
                w_mul_b = {1'b0, FILT_OLD_WT};
            end
            MUL_SSUM_NEW: begin
                w_mul_a = {{(MA_W-SSUM_W){r_ssum[SSUM_W-1]}}, r_ssum};
                w_mul_b = {1'b0, FILT_NEW_WT};
            end
            MUL_FILT_KP: begin
                w_mul_a = {r_filt[FILT_W-1], r_filt};
                w_mul_b = {1'b0, r_spd_kp};
            end
            MUL_INTEG_KI: begin
                w_mul_a = {{(MA_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ};
                w_mul_b = {1'b0, r_spd_ki};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_mul_a) * $signed(w_mul_b);
    end

    assign w_prod_ext = {r_prod[PROD_W-1], r_prod};
    assign w_acc_sum  = r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= w_prod_ext;
            ACC_ADD:  r_acc <= w_acc_sum;
            default: begin
            end
        endcase
    end

    // Division by 4096 truncated toward zero.
    assign w_upr_adj = r_acc + (r_acc[ACC_W-1] ? ACC_W'(4095) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_upright) begin
            r_upright <= w_upr_adj[UPR_W+11:12];
        end
    end

    // Integral update with saturation.
    assign w_integ_sum = {{3{r_integ[INTEG_W-1]}}, r_integ}
                         + {r_filt[FILT_W-1], r_filt};

    always_comb begin
        if ($signed(w_integ_sum) > $signed({3'b000, INTEG_LIMIT})) begin
            w_integ_next = INTEG_LIMIT;
        end else if ($signed(w_integ_sum) < -$signed({3'b000, INTEG_LIMIT})) begin
            w_integ_next = -INTEG_LIMIT;
        end else begin
            w_integ_next = w_integ_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            if (i_cmd.upd_filt) begin
                // Arithmetic shift by 8 rounds toward minus infinity.
                r_filt <= w_acc_sum[FILT_W+7:8];
            end
            if (i_cmd.upd_integ) begin
                r_integ <= w_integ_next;
            end
        end
    end

    // Speed term: division by 2^24 truncated toward zero, then the final sum.
    assign w_spd_adj = r_acc + (r_acc[ACC_W-1] ? ACC_W'(24'hFF_FFFF) : '0);
    assign w_speed   = w_spd_adj[SPD_W+23:24];
    assign w_sum     = {r_upright[UPR_W-1], r_upright}
                       + {{(SUM_W-SPD_W){w_speed[SPD_W-1]}}, w_speed};
    assign w_lim_pos = {{(SUM_W-LIM_W){1'b0}}, r_pwm_lim};
    assign w_lim_neg = -w_lim_pos;

    always_comb begin
        if ($signed(w_sum) > $signed(w_lim_pos)) begin
            w_drive = w_lim_pos[DRIVE_W-1:0];
        end else if ($signed(w_sum) < $signed(w_lim_neg)) begin
            w_drive = w_lim_neg[DRIVE_W-1:0];
        end else begin
            w_drive = w_sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_m_tdata <= w_drive;
            o_m_tuser <= ~w_sum[SUM_W-1] && (w_sum != '0);
        end
    end

    assign o_status.out_stall = o_m_tvalid && !i_m_tready;

endmodule

>>> design/balance_cascade_pd_pi_controller.sv
// Two-wheel balance controller: each input beat is one control tick carrying
// both wheel encoder counts, the tilt angle (Q8.8) and the tilt rate (Q16.8).
// The block forms the upright PD term, updates its speed low-pass filter and
// clamped speed integral, adds the speed PI term and returns one output beat
// with the drive value clamped to plus or minus pwm_limit and a flag that is
// high when the unclamped sum is above zero. The six products of a tick go
// one after another through the single shared 27 by 17 bit multiplier. One
// tick is worked on at a time; the next is accepted as soon as the previous
// result is in the output register, even while that result still waits to
// be taken.
// Gains and limits are written through the configuration port, which should
// only be used while no tick is in flight.
module balance_cascade_pd_pi_controller
    import bcpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // left_count [15:0], right_count [31:16], tilt_angle [47:32],
    // tilt_rate [71:48]
    input  logic [71:0]          i_s_tdata,
    // Output stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // drive [15:0]
    output logic [DRIVE_W-1:0]   o_m_tdata,
    // backward [0]
    output logic                 o_m_tuser
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The sequencer steps the datapath through the multiply and accumulate
    // schedule and holds the last step while the output beat waits to be taken.
    bcpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the configuration, the filter and integral state,
    // the shared multiplier with its accumulator and the output register.
    bcpd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
